// ===== sv/dldb_pkg.sv =====
// Shared constants, types and microcode store for the decimal-to-display byte unit.
`default_nettype none

package dldb_pkg;

  // Display command and character codes
  localparam logic [7:0] CMD_SET_ADDR = 8'h80;
  localparam logic [7:0] ROW2_OFFSET  = 8'h40;
  localparam logic [7:0] ASCII_ZERO   = 8'h30;

  // Field widths
  localparam int VALUE_W  = 24;
  localparam int COUNT_W  = 3;
  localparam int COLUMN_W = 6;

  // Largest count the digit-count field can carry
  localparam int COUNT_FIELD_MAX = 7;
  localparam int MAX_DIGITS_DEF  = 7;

  // Divide by ten: q = (v * RECIP) >> SHIFT, exact for every 24-bit v
  localparam logic [VALUE_W-1:0] DIV10_RECIP = 24'hCCCCCD;
  localparam int                 DIV10_SHIFT = 27;

  // Microprogram step addresses
  localparam logic [1:0] STEP_LOAD = 2'd0;
  localparam logic [1:0] STEP_DIV  = 2'd1;
  localparam logic [1:0] STEP_CMD  = 2'd2;
  localparam logic [1:0] STEP_DIG  = 2'd3;

  // Jump conditions
  localparam logic [2:0] COND_NONE        = 3'd0;
  localparam logic [2:0] COND_IN_CNT_ZERO = 3'd1;
  localparam logic [2:0] COND_CNT_ZERO    = 3'd2;
  localparam logic [2:0] COND_DIV_DONE    = 3'd3;
  localparam logic [2:0] COND_DIG_LAST    = 3'd4;

  typedef struct packed {
    logic       wait_in;   // hold until an input transfer is offered
    logic       wait_out;  // hold until the output register is free
    logic       load;
    logic       div;
    logic       emit_cmd;
    logic       emit_dig;
    logic [2:0] cond;
    logic [1:0] tgt;       // taken when cond is true
    logic [1:0] fall;      // taken otherwise
  } ucode_t;

  // Datapath strobes, already gated by the sequencer
  typedef struct packed {
    logic load;
    logic div;
    logic emit_cmd;
    logic emit_dig;
  } dp_ctl_t;

  // Datapath flags seen by the sequencer
  typedef struct packed {
    logic out_free;
    logic in_cnt_zero;
    logic cnt_zero;
    logic div_done;
    logic dig_last;
  } dp_stat_t;

  function automatic ucode_t ucode_rom(input logic [1:0] step);
    ucode_t w;
    w = '0;
    case (step)
      STEP_LOAD: begin
        w.wait_in = 1'b1;
        w.load    = 1'b1;
        w.cond    = COND_IN_CNT_ZERO;
        w.tgt     = STEP_CMD;
        w.fall    = STEP_DIV;
      end
      STEP_DIV: begin
        w.div  = 1'b1;
        w.cond = COND_DIV_DONE;
        w.tgt  = STEP_CMD;
        w.fall = STEP_DIV;
      end
      STEP_CMD: begin
        w.wait_out = 1'b1;
        w.emit_cmd = 1'b1;
        w.cond     = COND_CNT_ZERO;
        w.tgt      = STEP_LOAD;
        w.fall     = STEP_DIG;
      end
      STEP_DIG: begin
        w.wait_out = 1'b1;
        w.emit_dig = 1'b1;
        w.cond     = COND_DIG_LAST;
        w.tgt      = STEP_LOAD;
        w.fall     = STEP_DIG;
      end
      default: begin
        w.fall = STEP_LOAD;
      end
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// ===== sv/dldb_if.sv =====
// Valid/ready channel interfaces for input items and display bytes.
`default_nettype none

interface dldb_in_if
  import dldb_pkg::*;
;
  logic                valid;
  logic                ready;
  logic [VALUE_W-1:0]  value;
  logic [COUNT_W-1:0]  digit_count;
  logic [COLUMN_W-1:0] column;
  logic                row;

  modport source (output valid, output value, output digit_count, output column,
                  output row, input ready);
  modport sink   (input valid, input value, input digit_count, input column,
                  input row, output ready);
endinterface

interface dldb_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] lcd_byte;
  logic       is_data;
  logic       last;

  modport source (output valid, output lcd_byte, output is_data, output last,
                  input ready);
  modport sink   (input valid, input lcd_byte, input is_data, input last,
                  output ready);
endinterface

`default_nettype wire

// ===== sv/decimal_number_to_lcd_bytes_unit.sv =====
// Top level: binary number to set-address command plus zero-padded ASCII digits.
// The command byte is registered in the cmd step, which follows the load step and
//   the div steps; digits then follow one per cycle while the output register is free.
//   A new item is taken only after the last byte of the previous one is registered,
//   as the single divide-by-ten unit and the one-byte output register serve one item.
// Reset (rst_n low, synchronous): step counter returns to the load step and the
//   output register empties; operand and digit registers are not cleared.
`default_nettype none

module decimal_number_to_lcd_bytes_unit
  import dldb_pkg::*;
#(
  parameter int MAX_DIGITS = MAX_DIGITS_DEF
) (
  input wire logic  clk,
  input wire logic  rst_n,
  dldb_in_if.sink   in_ch,
  dldb_out_if.source out_ch
);

  // Control store program:
  //   load : wait for an input transfer, latch operands, saturate the count
  //   div  : peel one decimal digit per cycle, least significant first
  //   cmd  : send the set-address command (marked last when no digits asked for)
  //   dig  : send stored digits most significant first, last mark on the final one

  dp_ctl_t  ctl;
  dp_stat_t stat;
  logic     in_ready;

  dldb_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .stat     (stat),
    .in_ready (in_ready),
    .ctl      (ctl)
  );

  dldb_datapath #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_value       (in_ch.value),
    .in_digit_count (in_ch.digit_count),
    .in_column      (in_ch.column),
    .in_row         (in_ch.row),
    .ctl            (ctl),
    .stat           (stat),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .out_lcd_byte   (out_ch.lcd_byte),
    .out_is_data    (out_ch.is_data),
    .out_last       (out_ch.last)
  );

  // Ready only in the load step; the output register may still hold the
  // previous item's final byte while the next transfer is taken.
  assign in_ch.ready = in_ready;

endmodule

`default_nettype wire

// ===== sv/dldb_seq.sv =====
// Microcode sequencer: step counter, control store and conditional jumps.
`default_nettype none

module dldb_seq
  import dldb_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  input  wire dp_stat_t stat,
  output logic          in_ready,
  output dp_ctl_t       ctl
);

  logic [1:0] step_r, step_nxt;
  ucode_t     w;
  logic       stall;
  logic       cond_true;

  always_comb begin
    w     = ucode_rom(step_r);
    stall = (w.wait_in && !in_valid) || (w.wait_out && !stat.out_free);
    case (w.cond)
      COND_NONE:        cond_true = 1'b0;
      COND_IN_CNT_ZERO: cond_true = stat.in_cnt_zero;
      COND_CNT_ZERO:    cond_true = stat.cnt_zero;
      COND_DIV_DONE:    cond_true = stat.div_done;
      COND_DIG_LAST:    cond_true = stat.dig_last;
      default:          cond_true = 1'b0;
    endcase
    if (stall) begin
      step_nxt = step_r;
    end else if (cond_true) begin
      step_nxt = w.tgt;
    end else begin
      step_nxt = w.fall;
    end
    in_ready     = w.wait_in;
    ctl.load     = w.load && !stall;
    ctl.div      = w.div && !stall;
    ctl.emit_cmd = w.emit_cmd && !stall;
    ctl.emit_dig = w.emit_dig && !stall;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= STEP_LOAD;
    end else begin
      step_r <= step_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== sv/dldb_datapath.sv =====
// Datapath: operand registers, divide-by-ten step, digit store and output register.
`default_nettype none

module dldb_datapath
  import dldb_pkg::*;
#(
  parameter int MAX_DIGITS = MAX_DIGITS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic [VALUE_W-1:0]  in_value,
  input  wire logic [COUNT_W-1:0]  in_digit_count,
  input  wire logic [COLUMN_W-1:0] in_column,
  input  wire logic                in_row,
  input  wire dp_ctl_t             ctl,
  output dp_stat_t                 stat,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [7:0]               out_lcd_byte,
  output logic                     out_is_data,
  output logic                     out_last
);

  localparam int DEPTH = (MAX_DIGITS < COUNT_FIELD_MAX) ? MAX_DIGITS : COUNT_FIELD_MAX;
  localparam int KW    = $clog2(DEPTH + 1);
  localparam int IW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [VALUE_W-1:0]  value_r;
  logic [KW-1:0]       cnt_r;
  logic [KW-1:0]       k_r;
  logic [COLUMN_W-1:0] column_r;
  logic                row_r;
  logic [3:0]          digits_r [DEPTH];

  logic                out_valid_r;
  logic [7:0]          byte_r;
  logic                is_data_r;
  logic                last_r;

  logic [KW-1:0]        cnt_sat;
  logic [2*VALUE_W-1:0] prod;
  logic [VALUE_W-1:0]   quot;
  logic [VALUE_W-1:0]   quot10;
  logic [VALUE_W-1:0]   rem;
  logic [KW-1:0]        k_inc;
  logic [KW-1:0]        k_dec;
  logic [7:0]           cmd_byte;
  logic                 out_free;

  always_comb begin
    cnt_sat  = (in_digit_count > COUNT_W'(DEPTH)) ? KW'(DEPTH) : KW'(in_digit_count);
    prod     = {{VALUE_W{1'b0}}, value_r} * {{VALUE_W{1'b0}}, DIV10_RECIP};
    quot     = VALUE_W'(prod >> DIV10_SHIFT);
    quot10   = (quot << 3) + (quot << 1);
    rem      = value_r - quot10;
    k_inc    = k_r + KW'(1);
    k_dec    = k_r - KW'(1);
    cmd_byte = CMD_SET_ADDR + {2'b00, column_r} + (row_r ? ROW2_OFFSET : 8'h00);
    out_free = !out_valid_r || out_ready;

    stat.out_free    = out_free;
    stat.in_cnt_zero = (cnt_sat == '0);
    stat.cnt_zero    = (cnt_r == '0);
    stat.div_done    = (k_inc == cnt_r);
    stat.dig_last    = (k_r == KW'(1));
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      value_r  <= in_value;
      cnt_r    <= cnt_sat;
      column_r <= in_column;
      row_r    <= in_row;
      k_r      <= '0;
    end else if (ctl.div) begin
      value_r          <= quot;
      digits_r[k_r[IW-1:0]] <= rem[3:0];
      k_r              <= k_inc;
    end else if (ctl.emit_dig) begin
      k_r <= k_dec;
    end

    if (ctl.emit_cmd) begin
      byte_r    <= cmd_byte;
      is_data_r <= 1'b0;
      last_r    <= (cnt_r == '0);
    end else if (ctl.emit_dig) begin
      byte_r    <= ASCII_ZERO + {4'h0, digits_r[k_dec[IW-1:0]]};
      is_data_r <= 1'b1;
      last_r    <= (k_r == KW'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.emit_cmd || ctl.emit_dig) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_lcd_byte = byte_r;
  assign out_is_data  = is_data_r;
  assign out_last     = last_r;

endmodule

`default_nettype wire
